>>> rtl/line_position_pid_steering_defines.svh
// Assertion helpers for the checker in lpps_chk.sv.
// Each macro expects clk and rst to be visible where it is used.
`ifndef LINE_POSITION_PID_STEERING_DEFINES_SVH
`define LINE_POSITION_PID_STEERING_DEFINES_SVH

// Same-cycle implication
`define LPPS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define LPPS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/lpps_pkg.sv
package lpps_pkg;

  // Register file
  localparam int CFG_ADDR_W = 5;
  localparam logic [2:0] REG_GAIN_P    = 3'd0;
  localparam logic [2:0] REG_GAIN_I    = 3'd1;
  localparam logic [2:0] REG_GAIN_D    = 3'd2;
  localparam logic [2:0] REG_BASE_DUTY = 3'd3;
  localparam logic [2:0] REG_MIN_DUTY  = 3'd4;
  localparam logic [2:0] REG_MAX_DUTY  = 3'd5;

  // Raw reading thresholds: mapped value above 700 means raw <= 1228,
  // exactly 700 means raw in 1229..1232, below 700 means raw >= 1233.
  localparam logic [11:0] RAW_ON_MAX   = 12'd1228;
  localparam logic [11:0] RAW_HOLD_MAX = 12'd1232;

  localparam logic signed [15:0] LOST_ERROR  = 16'sd6400;
  localparam logic signed [15:0] INTEG_LIMIT = 16'sd7680;

  localparam int ACC_W = 38;

  typedef struct packed {
    logic [15:0] gain_p;
    logic [15:0] gain_i;
    logic [15:0] gain_d;
    logic [6:0]  base_duty;
    logic [6:0]  min_duty;
    logic [6:0]  max_duty;
  } cfg_t;

  typedef enum logic [1:0] {
    MUL_P = 2'd0,
    MUL_I = 2'd1,
    MUL_D = 2'd2
  } mul_sel_t;

  typedef struct packed {
    logic     load_in;
    logic     calc_err;
    logic     mul_en;
    logic     mul_first;
    mul_sel_t mul_sel;
    logic     duty_en;
    logic     duty_right;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic out_full;
  } dp_status_t;

  // round(m * 2560 / n) for m = 0..9, n = 1..5; ties cannot occur
  function automatic logic [14:0] err_mag(input logic [3:0] m, input logic [2:0] n);
    logic [14:0] mm;
    logic [14:0] r;
    mm = {11'd0, m};
    r  = '0;
    case (n)
      3'd1: r = (mm << 11) + (mm << 9);
      3'd2: r = (mm << 10) + (mm << 8);
      3'd4: r = (mm << 9) + (mm << 7);
      3'd5: r = mm << 9;
      3'd3: begin
        case (m)
          4'd1: r = 15'd853;
          4'd2: r = 15'd1707;
          4'd3: r = 15'd2560;
          4'd4: r = 15'd3413;
          4'd5: r = 15'd4267;
          4'd6: r = 15'd5120;
          4'd7: r = 15'd5973;
          4'd8: r = 15'd6827;
          4'd9: r = 15'd7680;
          default: r = '0;
        endcase
      end
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/line_position_pid_steering.sv
// Channel   Dir  Payload (low bit up)
// s_*       in   sensor_0, sensor_1, sensor_2, sensor_3, sensor_4 (12 b each)
// m_*       out  left_duty, right_duty, line_error (15 b each)
// apb       in   gain_p, gain_i, gain_d, base_duty, min_duty, max_duty at 4*i
//
// One item walks the sequencer through its steps: flags on transfer, the
// position error, the P, I and D products on the single gain multiplier,
// left then right duty clamp, then loading the output register, which
// raises output valid.
// Input ready rises in the same cycle as output valid; the next input is taken even if the result still waits.
// A full output register stalls the sequencer in its last step only.
// Synchronous reset restores register defaults and clears error history.
module line_position_pid_steering
  import lpps_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // sensor_0 [11:0], sensor_1 [23:12], sensor_2 [35:24], sensor_3 [47:36],
  // sensor_4 [59:48], zero [63:60]
  input  logic [63:0]           s_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // left_duty [14:0], right_duty [29:15], line_error [44:30], zero [47:45]
  output logic [47:0]           m_tdata,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  cfg_t             cfg;
  dp_cmd_t          cmd;
  dp_status_t       status;
  logic [4:0][11:0] sensor;

  assign sensor = s_tdata[59:0];

  lpps_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lpps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .s_tready (s_tready),
    .cmd      (cmd)
  );

  lpps_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .cmd      (cmd),
    .sensor   (sensor),
    .m_tready (m_tready),
    .status   (status),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata)
  );

endmodule

>>> rtl/lpps_cfg.sv
module lpps_cfg
  import lpps_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  logic [2:0] idx;
  logic       wr;

  assign idx    = paddr[CFG_ADDR_W-1:2];
  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_p    <= 16'd256;
      cfg.gain_i    <= 16'd0;
      cfg.gain_d    <= 16'd0;
      cfg.base_duty <= 7'd68;
      cfg.min_duty  <= 7'd55;
      cfg.max_duty  <= 7'd81;
    end else if (wr) begin
      case (idx)
        REG_GAIN_P:    cfg.gain_p    <= pwdata[15:0];
        REG_GAIN_I:    cfg.gain_i    <= pwdata[15:0];
        REG_GAIN_D:    cfg.gain_d    <= pwdata[15:0];
        REG_BASE_DUTY: cfg.base_duty <= pwdata[6:0];
        REG_MIN_DUTY:  cfg.min_duty  <= pwdata[6:0];
        REG_MAX_DUTY:  cfg.max_duty  <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (idx)
      REG_GAIN_P:    prdata = {16'd0, cfg.gain_p};
      REG_GAIN_I:    prdata = {16'd0, cfg.gain_i};
      REG_GAIN_D:    prdata = {16'd0, cfg.gain_d};
      REG_BASE_DUTY: prdata = {25'd0, cfg.base_duty};
      REG_MIN_DUTY:  prdata = {25'd0, cfg.min_duty};
      REG_MAX_DUTY:  prdata = {25'd0, cfg.max_duty};
      default:       prdata = '0;
    endcase
  end

endmodule

>>> rtl/lpps_ctrl.sv
module lpps_ctrl
  import lpps_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  input  logic       m_tready,
  input  dp_status_t status,
  output logic       s_tready,
  output dp_cmd_t    cmd
);

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_ERR    = 8'b0000_0010,
    ST_MUL_P  = 8'b0000_0100,
    ST_MUL_I  = 8'b0000_1000,
    ST_MUL_D  = 8'b0001_0000,
    ST_DUTY_L = 8'b0010_0000,
    ST_DUTY_R = 8'b0100_0000,
    ST_DONE   = 8'b1000_0000
  } state_t;

  state_t state, state_next;
  logic   out_free;

  assign out_free = !status.out_full || m_tready;
  assign s_tready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencing and commands
  always_comb begin
    state_next     = state;
    cmd            = '0;
    cmd.mul_sel    = MUL_P;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load_in = 1'b1;
          state_next  = ST_ERR;
        end
      end
      ST_ERR: begin
        cmd.calc_err = 1'b1;
        state_next   = ST_MUL_P;
      end
      ST_MUL_P: begin
        cmd.mul_en    = 1'b1;
        cmd.mul_first = 1'b1;
        cmd.mul_sel   = MUL_P;
        state_next    = ST_MUL_I;
      end
      ST_MUL_I: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_I;
        state_next  = ST_MUL_D;
      end
      ST_MUL_D: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_D;
        state_next  = ST_DUTY_L;
      end
      ST_DUTY_L: begin
        cmd.duty_en = 1'b1;
        state_next  = ST_DUTY_R;
      end
      ST_DUTY_R: begin
        cmd.duty_en    = 1'b1;
        cmd.duty_right = 1'b1;
        state_next     = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

>>> rtl/lpps_dp.sv
module lpps_dp
  import lpps_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  cfg_t             cfg,
  input  dp_cmd_t          cmd,
  input  logic [4:0][11:0] sensor,
  input  logic             m_tready,
  output dp_status_t       status,
  output logic             m_tvalid,
  output logic [47:0]      m_tdata
);

  // Item registers
  logic [4:0]             flags;
  logic signed [15:0]     err_r;
  logic signed [16:0]     diff_r;
  logic signed [13:0]     integ_r;
  logic signed [ACC_W-1:0] acc;
  logic [14:0]            left_r;
  logic [14:0]            right_r;

  // Loop state
  logic signed [15:0]     last_error;
  logic signed [13:0]     error_integral;

  // On-line flag chain over the raw readings
  logic [4:0] flags_d;
  always_comb begin
    logic f;
    f = 1'b0;
    for (int i = 0; i < 5; i++) begin
      if (sensor[i] <= RAW_ON_MAX) begin
        f = 1'b1;
      end else if (sensor[i] > RAW_HOLD_MAX) begin
        f = 1'b0;
      end
      flags_d[i] = f;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      flags <= flags_d;
    end
  end

  // Position error, difference and clamped integral
  logic [2:0]         cnt;
  logic signed [4:0]  wsum;
  logic signed [4:0]  wm1;
  logic [3:0]         mag_idx;
  logic [14:0]        mag;
  logic signed [15:0] err_d;
  logic signed [16:0] diff_d;
  logic signed [15:0] isum;
  logic signed [15:0] integ_d;

  always_comb begin
    cnt = 3'(flags[0]) + 3'(flags[1]) + 3'(flags[2]) + 3'(flags[3]) + 3'(flags[4]);
    wsum = (flags[0] ? -5'sd5 : 5'sd0) + (flags[1] ? -5'sd3 : 5'sd0)
         + (flags[2] ? 5'sd1 : 5'sd0) + (flags[3] ? 5'sd3 : 5'sd0)
         + (flags[4] ? 5'sd5 : 5'sd0);
    wm1     = wsum - 5'sd1;
    mag_idx = wm1[4] ? 4'(-wm1) : wm1[3:0];
    mag     = err_mag(mag_idx, cnt);
    if (cnt == 3'd0) begin
      err_d = (last_error > 16'sd0) ? LOST_ERROR : -LOST_ERROR;
    end else if (wm1[4]) begin
      err_d = -$signed({1'b0, mag});
    end else begin
      err_d = $signed({1'b0, mag});
    end
    diff_d = 17'(err_d) - 17'(last_error);
    isum   = 16'(error_integral) + err_d;
    if (isum > INTEG_LIMIT) begin
      integ_d = INTEG_LIMIT;
    end else if (isum < -INTEG_LIMIT) begin
      integ_d = -INTEG_LIMIT;
    end else begin
      integ_d = isum;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.calc_err) begin
      err_r   <= err_d;
      diff_r  <= diff_d;
      integ_r <= integ_d[13:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_error     <= '0;
      error_integral <= '0;
    end else if (cmd.calc_err) begin
      last_error     <= err_d;
      error_integral <= integ_d[13:0];
    end
  end

  // Shared multiply-accumulate: gain times term, one term per cycle
  logic [15:0]        mul_gain;
  logic signed [16:0] mul_term;
  logic signed [33:0] prod;

  always_comb begin
    case (cmd.mul_sel)
      MUL_P: begin
        mul_gain = cfg.gain_p;
        mul_term = 17'(err_r);
      end
      MUL_I: begin
        mul_gain = cfg.gain_i;
        mul_term = 17'(integ_r);
      end
      MUL_D: begin
        mul_gain = cfg.gain_d;
        mul_term = diff_r;
      end
      default: begin
        mul_gain = '0;
        mul_term = '0;
      end
    endcase
    prod = $signed({1'b0, mul_gain}) * mul_term;
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      acc <= (cmd.mul_first ? '0 : acc) + ACC_W'(prod);
    end
  end

  // Duty clamp and rounding to Q.8, left then right
  logic signed [ACC_W-1:0] base16;
  logic signed [ACC_W-1:0] lo16;
  logic signed [ACC_W-1:0] hi16;
  logic signed [ACC_W-1:0] dsum;
  logic signed [ACC_W-1:0] dlo;
  logic signed [ACC_W-1:0] dclamp;
  logic [23:0]             drnd;
  logic [14:0]             duty;

  always_comb begin
    base16 = $signed({{(ACC_W-23){1'b0}}, cfg.base_duty, 16'd0});
    lo16   = $signed({{(ACC_W-23){1'b0}}, cfg.min_duty, 16'd0});
    hi16   = $signed({{(ACC_W-23){1'b0}}, cfg.max_duty, 16'd0});
    dsum   = cmd.duty_right ? (base16 - acc) : (base16 + acc);
    dlo    = (dsum < lo16) ? lo16 : dsum;
    dclamp = (dlo > hi16) ? hi16 : dlo;
    drnd   = {1'b0, dclamp[22:0]} + 24'd128;
    duty   = drnd[22:8];
  end

  always_ff @(posedge clk) begin
    if (cmd.duty_en) begin
      if (cmd.duty_right) begin
        right_r <= duty;
      end else begin
        left_r <= duty;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= {3'd0, err_r[14:0], right_r, left_r};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign status.out_full = m_tvalid;

endmodule

>>> rtl/lpps_chk.sv
`include "line_position_pid_steering_defines.svh"

module lpps_chk
  import lpps_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata
);

  // Stalled result holds
  `LPPS_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped or changed while stalled")

  // One item in flight: busy right after an input transfer
  `LPPS_ASSERT_NXT(a_busy_after_in, s_tvalid && s_tready, !s_tready, "input taken while an item is in flight")

  // A new result rises only when the input side was closed just before it
  `LPPS_ASSERT_IMP(a_result_after_work, $rose(m_tvalid), $past(!s_tready), "result appeared without work in flight")

  // Duty values stay within 127 percent in Q.8
  `LPPS_ASSERT_IMP(a_duty_range, m_tvalid, (m_tdata[14:0] <= 15'd32512) && (m_tdata[29:15] <= 15'd32512), "duty out of range")

  // Line error stays within the reachable span
  `LPPS_ASSERT_IMP(a_err_range, m_tvalid, ($signed(m_tdata[44:30]) >= -15'sd15360) && ($signed(m_tdata[44:30]) <= 15'sd10240), "line error out of range")

endmodule

bind line_position_pid_steering lpps_chk u_lpps_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

>>> verif/steering_checker.sv
module steering_checker
  import lpps_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  // sensor_0 [11:0] .. sensor_4 [59:48], zero [63:60]
  input  logic [63:0]           s_tdata,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  // left_duty [14:0], right_duty [29:15], line_error [44:30], zero [47:45]
  input  logic [47:0]           m_tdata,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  input  logic                  pready,
  output int                    mismatches,
  output int                    outstanding
);

  localparam int ON_LEVEL       = 700;
  localparam int ADC_FULL_SCALE = 4095;
  localparam int MAP_RANGE      = 1000;
  localparam int LOST_LINE_ERR  = 6400;
  localparam int INTEGRAL_CLAMP = 7680;
  localparam int SENSOR_WEIGHT [5] = '{-5, -3, 1, 3, 5};
  localparam int MAX_PRINTED    = 100;

  // Same bit order as m_tdata[44:0]
  typedef struct packed {
    logic [14:0] line_error;
    logic [14:0] right_duty;
    logic [14:0] left_duty;
  } steer_t;

  cfg_t   steer_cfg;
  int     last_err;
  int     err_integral;
  steer_t expected_q[$];

  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_PRINTED) $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // Clamp a Q.16 duty into the configured bounds and round to Q.8
  function automatic logic [14:0] clamp_duty(input longint q16);
    longint lo;
    longint hi;
    longint v;
    lo = longint'(steer_cfg.min_duty) * 65536;
    hi = longint'(steer_cfg.max_duty) * 65536;
    v  = q16;
    if (v < lo) v = lo;
    if (v > hi) v = hi;
    return 15'((v + 128) >>> 8);
  endfunction

  // Weighted position and PID step; updates the error history
  function automatic steer_t predict_steering(input logic [63:0] frame);
    int     raw;
    int     level;
    int     on_line;
    int     hits;
    int     wsum;
    int     num;
    int     mag;
    int     err;
    int     diff;
    int     integ;
    longint corr;
    longint base16;
    steer_t res;
    on_line = 0;
    hits    = 0;
    wsum    = 0;
    for (int i = 0; i < 5; i++) begin
      raw   = int'(frame[12*i +: 12]);
      level = MAP_RANGE - (raw * MAP_RANGE) / ADC_FULL_SCALE;
      // exactly on the level keeps the neighbor's flag
      if (level > ON_LEVEL) on_line = 1;
      else if (level < ON_LEVEL) on_line = 0;
      wsum += SENSOR_WEIGHT[i] * on_line;
      hits += on_line;
    end
    if (hits == 0) begin
      err = (last_err > 0) ? LOST_LINE_ERR : -LOST_LINE_ERR;
    end else begin
      num = (wsum - 1) * 2560;
      mag = (num < 0) ? -num : num;
      mag = (mag + hits / 2) / hits;
      err = (num < 0) ? -mag : mag;
    end
    diff  = err - last_err;
    integ = err_integral + err;
    if (integ > INTEGRAL_CLAMP) integ = INTEGRAL_CLAMP;
    if (integ < -INTEGRAL_CLAMP) integ = -INTEGRAL_CLAMP;
    corr = longint'(steer_cfg.gain_p) * longint'(err)
         + longint'(steer_cfg.gain_i) * longint'(integ)
         + longint'(steer_cfg.gain_d) * longint'(diff);
    base16 = longint'(steer_cfg.base_duty) * 65536;
    res.left_duty  = clamp_duty(base16 + corr);
    res.right_duty = clamp_duty(base16 - corr);
    res.line_error = 15'(err);
    last_err     = err;
    err_integral = integ;
    return res;
  endfunction

  // Watch all channels on the clock edge
  always @(posedge clk) begin
    steer_t got;
    steer_t want;
    if (rst) begin
      steer_cfg.gain_p    = 16'd256;
      steer_cfg.gain_i    = 16'd0;
      steer_cfg.gain_d    = 16'd0;
      steer_cfg.base_duty = 7'd68;
      steer_cfg.min_duty  = 7'd55;
      steer_cfg.max_duty  = 7'd81;
      last_err     = 0;
      err_integral = 0;
      expected_q.delete();
      outstanding <= 0;
    end else begin
      // result transfer against the oldest prediction
      if (m_tvalid && m_tready) begin
        got = steer_t'(m_tdata[44:0]);
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("result %h with nothing outstanding", m_tdata));
        end else begin
          want = expected_q.pop_front();
          if (got.left_duty != want.left_duty)
            report_mismatch($sformatf("left_duty got %0d expected %0d",
                                      got.left_duty, want.left_duty));
          if (got.right_duty != want.right_duty)
            report_mismatch($sformatf("right_duty got %0d expected %0d",
                                      got.right_duty, want.right_duty));
          if (got.line_error != want.line_error)
            report_mismatch($sformatf("line_error got %0d expected %0d",
                                      $signed(got.line_error), $signed(want.line_error)));
        end
      end
      // sensor frame transfer
      if (s_tvalid && s_tready) expected_q.push_back(predict_steering(s_tdata));
      // register write
      if (psel && penable && pwrite && pready) begin
        case (paddr[CFG_ADDR_W-1:2])
          REG_GAIN_P:    steer_cfg.gain_p    = pwdata[15:0];
          REG_GAIN_I:    steer_cfg.gain_i    = pwdata[15:0];
          REG_GAIN_D:    steer_cfg.gain_d    = pwdata[15:0];
          REG_BASE_DUTY: steer_cfg.base_duty = pwdata[6:0];
          REG_MIN_DUTY:  steer_cfg.min_duty  = pwdata[6:0];
          REG_MAX_DUTY:  steer_cfg.max_duty  = pwdata[6:0];
          default: ;
        endcase
      end
      outstanding <= expected_q.size();
    end
  end

endmodule

>>> verif/tb_line_position_pid_steering.sv
module tb_line_position_pid_steering;
  import lpps_pkg::*;

  localparam int FRAMES_PER_SEGMENT = 275;
  localparam int SEGMENTS           = 6;
  localparam int TAIL_CYCLES        = 20;

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic [63:0]           s_tdata  = '0;
  logic                  m_tready = 1'b0;
  logic                  psel     = 1'b0;
  logic                  penable  = 1'b0;
  logic                  pwrite   = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr    = '0;
  logic [31:0]           pwdata   = '0;
  logic                  s_tready;
  logic                  m_tvalid;
  logic [47:0]           m_tdata;
  logic [31:0]           prdata;
  logic                  pready;
  int                    mismatches;
  int                    outstanding;
  int                    send_idle_pct = 0;
  int                    recv_idle_pct = 0;

  line_position_pid_steering dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  steering_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .pready      (pready),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Receiver stalls at random
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic logic [63:0] pack_frame(input logic [11:0] s0, s1, s2, s3, s4);
    return {4'd0, s4, s3, s2, s1, s0};
  endfunction

  // Mostly a line of contiguous dark sensors, some lost frames, some noise
  function automatic logic [63:0] make_random_frame();
    logic [11:0] rd [5];
    int kind;
    int center;
    int width;
    int offset;
    kind   = $urandom_range(99);
    center = $urandom_range(4);
    width  = $urandom_range(5, 1);
    for (int i = 0; i < 5; i++) begin
      offset = (i > center) ? i - center : center - i;
      if (kind < 15) rd[i] = 12'($urandom_range(4095, 1233));
      else if (kind < 40) rd[i] = 12'($urandom);
      else if ($urandom_range(9) == 0) rd[i] = 12'($urandom_range(1232, 1229));
      else if (offset * 2 < width) rd[i] = 12'($urandom_range(1228, 0));
      else rd[i] = 12'($urandom_range(4095, 1233));
    end
    return pack_frame(rd[0], rd[1], rd[2], rd[3], rd[4]);
  endfunction

  task automatic set_idle(input int snd, input int rcv);
    send_idle_pct = snd;
    recv_idle_pct = rcv;
  endtask

  task automatic send_frame(input logic [63:0] frame);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= frame;
    do @(posedge clk); while (!s_tready);
  endtask

  // Hold the sender until every predicted result has been transferred
  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Setup then access; psel stays up across back-to-back writes
  task automatic apb_write(input logic [2:0] index, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'({index, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic apply_config(input logic [15:0] gp, gi, gd, input logic [6:0] base, lo, hi);
    apb_write(REG_GAIN_P, 32'(gp));
    apb_write(REG_GAIN_I, 32'(gi));
    apb_write(REG_GAIN_D, 32'(gd));
    apb_write(REG_BASE_DUTY, 32'(base));
    apb_write(REG_MIN_DUTY, 32'(lo));
    apb_write(REG_MAX_DUTY, 32'(hi));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Stimulus and verdict
  initial begin
    logic [63:0] directed [13];
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    directed = '{
      pack_frame(12'd0, 12'd0, 12'd0, 12'd0, 12'd0),                // all on line
      pack_frame(12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095), // lost, no history
      pack_frame(12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd0),    // far right
      pack_frame(12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095), // lost after right
      pack_frame(12'd0, 12'd4095, 12'd4095, 12'd4095, 12'd4095),    // far left
      pack_frame(12'd1228, 12'd4095, 12'd4095, 12'd4095, 12'd4095), // darkest off level
      pack_frame(12'd1229, 12'd4095, 12'd4095, 12'd4095, 12'd4095), // on level, start flag
      pack_frame(12'd0, 12'd1232, 12'd1229, 12'd1233, 12'd4095),    // level holds a run
      pack_frame(12'd4095, 12'd0, 12'd1230, 12'd1231, 12'd1232),
      pack_frame(12'd0, 12'd4095, 12'd0, 12'd4095, 12'd0),
      pack_frame(12'd4095, 12'd4095, 12'd0, 12'd4095, 12'd4095),
      pack_frame(12'd4095, 12'd0, 12'd0, 12'd4095, 12'd4095),
      pack_frame(12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd1228)
    };

    // Directed frames under reset defaults, then under full gains
    set_idle(19, 86);
    for (int pass = 0; pass < 2; pass++) begin
      if (pass == 1) begin
        drain_results();
        apply_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 7'd100, 7'd0, 7'd100);
      end
      foreach (directed[j]) send_frame(directed[j]);
    end

    // Random segments, each under its own register setting
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      drain_results();
      case (seg)
        0: apply_config(16'd256, 16'd32, 16'd128, 7'd68, 7'd55, 7'd81);
        1: apply_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 7'd100, 7'd0, 7'd100);
        2: apply_config(16'd0, 16'd0, 16'd0, 7'd0, 7'd0, 7'd0);
        3: apply_config(16'($urandom_range(1023)), 16'($urandom_range(255)),
                        16'($urandom_range(1023)), 7'($urandom_range(100)),
                        7'($urandom_range(100, 60)), 7'($urandom_range(40)));
        4: apply_config(16'($urandom_range(1023)), 16'($urandom_range(255)),
                        16'($urandom_range(1023)), 7'($urandom_range(100, 30)),
                        7'($urandom_range(30)), 7'($urandom_range(100, 70)));
        default: apply_config(16'($urandom), 16'($urandom), 16'($urandom),
                              7'($urandom_range(100)), 7'($urandom_range(50)),
                              7'($urandom_range(100, 50)));
      endcase
      case (seg / 2)
        0: set_idle(19, 86);
        1: set_idle(86, 19);
        default: set_idle(0, 0);
      endcase
      for (int k = 0; k < FRAMES_PER_SEGMENT; k++) begin
        if (k == FRAMES_PER_SEGMENT / 2) drain_results();
        send_frame(make_random_frame());
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/lpps_pkg.sv
rtl/lpps_cfg.sv
rtl/lpps_ctrl.sv
rtl/lpps_dp.sv
rtl/line_position_pid_steering.sv
rtl/lpps_chk.sv
verif/steering_checker.sv
verif/tb_line_position_pid_steering.sv
